@@ rtl/core/b128_pkg.sv @@
// Shared types, constants and the symbol escape table of the base-128 stream encoder.
package b128_pkg;

    localparam int LINE_LEN_W  = 10;
    localparam int BYTE_W      = 8;
    localparam int SYM_W       = 7;
    localparam int GROUP_BYTES = 7;
    localparam int GROUP_SYMS  = 8;
    localparam int GROUP_W     = GROUP_BYTES * BYTE_W;
    localparam int FILL_W      = 3;
    localparam int SYM_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LINE_LEN_W-1:0] LINE_LEN_RESET = 10'd64;

    localparam logic [SYM_W-1:0] CH_COLON = 7'h3A;
    localparam logic [SYM_W-1:0] CH_LF    = 7'h0A;

    typedef struct packed {
        logic [GROUP_W-1:0] bits;
        logic               last;
    } group_t;

    typedef struct packed {
        logic             esc;
        logic [SYM_W-1:0] code;
    } esc_t;

    function automatic esc_t escape_lookup(input logic [SYM_W-1:0] sym);
        esc_t r;
        r.esc  = 1'b1;
        r.code = CH_COLON;
        case (sym)
            7'h3A: r.code = CH_COLON;
            7'h00: r.code = 7'h30;
            7'h02: r.code = 7'h32;
            7'h03: r.code = 7'h33;
            7'h04: r.code = 7'h34;
            7'h05: r.code = 7'h35;
            7'h0D: r.code = 7'h41;
            7'h0A: r.code = 7'h42;
            7'h08: r.code = 7'h43;
            7'h09: r.code = 7'h44;
            7'h5E: r.code = 7'h45;
            default: begin
                r.esc  = 1'b0;
                r.code = sym;
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/b128_front.sv @@
// Front end: collects input bytes into groups of seven, or fewer at a message end, and hands finished groups on.
module b128_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte
    input  logic                 s_tlast,   // message_end
    input  logic                 q_full,
    output logic                 q_push,
    output b128_pkg::group_t     q_data
);

    logic [b128_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [b128_pkg::BYTE_W-1:0] store_reg [b128_pkg::GROUP_BYTES];
    logic                        accept;
    logic                        complete;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign complete = (fill_reg == b128_pkg::FILL_W'(b128_pkg::GROUP_BYTES - 1)) || s_tlast;
    assign q_push   = accept && complete;

    always_comb begin
        for (int k = 0; k < b128_pkg::GROUP_BYTES; k++) begin
            if (b128_pkg::FILL_W'(k) == fill_reg) begin
                q_data.bits[b128_pkg::GROUP_W-1-b128_pkg::BYTE_W*k -: b128_pkg::BYTE_W] = s_tdata;
            end else if (b128_pkg::FILL_W'(k) < fill_reg) begin
                q_data.bits[b128_pkg::GROUP_W-1-b128_pkg::BYTE_W*k -: b128_pkg::BYTE_W] =
                    store_reg[k];
            end else begin
                q_data.bits[b128_pkg::GROUP_W-1-b128_pkg::BYTE_W*k -: b128_pkg::BYTE_W] = '0;
            end
        end
        q_data.last = s_tlast;
    end

    always_comb begin
        fill_next = fill_reg;
        if (accept) begin
            if (complete) begin
                fill_next = '0;
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !complete) begin
            store_reg[fill_reg] <= s_tdata;
        end
    end

endmodule

@@ rtl/core/b128_queue.sv @@
// Two-entry group queue between the front end and the character sequencer.
module b128_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  b128_pkg::group_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output b128_pkg::group_t head_data
);

    localparam int PTR_W = $clog2(b128_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(b128_pkg::QUEUE_DEPTH + 1);

    b128_pkg::group_t  entry_reg [b128_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(b128_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(b128_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(b128_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/b128_back.sv @@
// Back end: cuts a group into symbols, escapes them, inserts line feeds and drives the output beat.
module b128_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [b128_pkg::LINE_LEN_W-1:0]   line_length,
    input  logic                              q_valid,
    input  b128_pkg::group_t                  q_data,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // out_char, zero bit
    output logic                              m_tlast,   // stream_last
    output logic                              m_tuser    // run_last
);

    logic                                busy_reg, busy_next;
    logic [b128_pkg::GROUP_W-1:0]        grp_reg, grp_next;
    logic                                last_reg, last_next;
    logic [b128_pkg::SYM_IDX_W-1:0]      sym_idx_reg, sym_idx_next;
    logic                                phase_reg, phase_next;
    logic [b128_pkg::LINE_LEN_W-1:0]     pos_reg, pos_next;
    logic                                lf_sent_reg, lf_sent_next;
    logic                                ovalid_reg, ovalid_next;
    logic [b128_pkg::SYM_W-1:0]          ochar_reg, ochar_next;
    logic                                orun_reg, orun_next;
    logic                                ostream_reg, ostream_next;

    logic [b128_pkg::SYM_W-1:0]          sym;
    b128_pkg::esc_t                      esc;
    logic                                lf_needed;
    logic                                sym_done;
    logic                                grp_done;
    logic                                adv;
    logic [b128_pkg::SYM_W-1:0]          ch;

    assign sym       = grp_reg[b128_pkg::GROUP_W-1 -: b128_pkg::SYM_W];
    assign esc       = b128_pkg::escape_lookup(sym);
    // a line feed is always followed by a character, even at line length zero
    assign lf_needed = !lf_sent_reg && (pos_reg >= line_length);
    assign sym_done  = !lf_needed && (phase_reg || !esc.esc);
    assign grp_done  = sym_done && (sym_idx_reg == b128_pkg::SYM_IDX_W'(b128_pkg::GROUP_SYMS - 1));
    assign adv       = busy_reg && (!ovalid_reg || m_tready);
    assign q_pop     = !busy_reg && q_valid;

    always_comb begin
        if (lf_needed) begin
            ch = b128_pkg::CH_LF;
        end else if (phase_reg) begin
            ch = esc.code;
        end else if (esc.esc) begin
            ch = b128_pkg::CH_COLON;
        end else begin
            ch = sym;
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        grp_next     = grp_reg;
        last_next    = last_reg;
        sym_idx_next = sym_idx_reg;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        lf_sent_next = lf_sent_reg;
        ovalid_next  = ovalid_reg;
        ochar_next   = ochar_reg;
        orun_next    = orun_reg;
        ostream_next = ostream_reg;

        if (adv) begin
            ovalid_next  = 1'b1;
            ochar_next   = ch;
            orun_next    = grp_done;
            ostream_next = grp_done && last_reg;
            lf_sent_next = lf_needed;
            if (lf_needed || (grp_done && last_reg)) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
            if (!lf_needed) begin
                if (sym_done) begin
                    phase_next   = 1'b0;
                    sym_idx_next = sym_idx_reg + 1'b1;
                    grp_next     = {grp_reg[b128_pkg::GROUP_W-b128_pkg::SYM_W-1:0],
                                    {b128_pkg::SYM_W{1'b0}}};
                end else begin
                    phase_next = 1'b1;
                end
            end
            if (grp_done) begin
                busy_next = 1'b0;
            end
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end

        if (q_pop) begin
            busy_next    = 1'b1;
            grp_next     = q_data.bits;
            last_next    = q_data.last;
            sym_idx_next = '0;
            phase_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            sym_idx_reg <= '0;
            phase_reg   <= 1'b0;
            pos_reg     <= '0;
            lf_sent_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            sym_idx_reg <= sym_idx_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            lf_sent_reg <= lf_sent_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg     <= grp_next;
        last_reg    <= last_next;
        ochar_reg   <= ochar_next;
        orun_reg    <= orun_next;
        ostream_reg <= ostream_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {1'b0, ochar_reg};
    assign m_tlast  = ostream_reg;
    assign m_tuser  = orun_reg;

endmodule

@@ rtl/core/base128_stream_encoder.sv @@
// Base-128 stream encoder: top level with the line length register.
//
// Bytes are taken one per beat and packed, seven at a time, into eight 7-bit
// symbols (a final partial group is padded with zeros); each symbol is escaped
// to one or two characters and a line feed is inserted whenever a line reaches
// line_length characters. The character sequencer emits one character per
// cycle while the output is not stalled, so a group of seven bytes costs its
// 8 to 32 characters plus a fetch of the group from the two-entry queue. The
// input side takes a byte every cycle until that queue is full; in steady
// state the output character rate sets the throughput, and a message shorter
// than seven bytes still costs a whole group of 8 to 32 characters. Writes to
// line_length take effect on the next character and belong to idle periods.
module base128_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [9:0] cfg_wr_data,   // line_length
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // data_byte
    input  logic       s_tlast,       // message_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // out_char, zero bit
    output logic       m_tlast,       // stream_last
    output logic       m_tuser        // run_last
);

    logic [b128_pkg::LINE_LEN_W-1:0] line_len_reg;
    logic                            q_full;
    logic                            q_push;
    b128_pkg::group_t                q_in;
    logic                            q_pop;
    logic                            q_valid;
    b128_pkg::group_t                q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg <= b128_pkg::LINE_LEN_RESET;
        end else if (cfg_wr_en) begin
            line_len_reg <= cfg_wr_data;
        end
    end

    b128_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    b128_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_out)
    );

    b128_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .line_length (line_len_reg),
        .q_valid     (q_valid),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the base-128 stream encoder: predictor, stimulus and checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 10;

    typedef logic [0:b128_pkg::GROUP_SYMS-1][b128_pkg::SYM_W-1:0]   sym_group_t;
    typedef logic [0:b128_pkg::GROUP_BYTES-1][b128_pkg::BYTE_W-1:0] byte_group_t;

    typedef struct packed {
        logic [b128_pkg::SYM_W-1:0] ch;
        logic                       run_last;
        logic                       stream_last;
    } enc_char_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [b128_pkg::LINE_LEN_W-1:0] cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata     = '0;
    logic                            s_tlast     = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [7:0]                      m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;

    base128_stream_encoder i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),   // line_length
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),       // data_byte
        .s_tlast     (s_tlast),       // message_end
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),       // out_char, zero bit
        .m_tlast     (m_tlast),       // stream_last
        .m_tuser     (m_tuser)        // run_last
    );

    always #1 aclk = ~aclk;

    // predictor state
    byte_group_t                     pending_bytes = '0;
    logic [b128_pkg::FILL_W-1:0]     pending_fill  = '0;
    logic [b128_pkg::LINE_LEN_W-1:0] line_pos      = '0;
    logic [b128_pkg::LINE_LEN_W-1:0] line_len      = b128_pkg::LINE_LEN_RESET;
    logic [b128_pkg::SYM_W-1:0]      group_chars[$];
    enc_char_t                       expected_chars[$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int errors    = 0;
    int bytes_sent = 0;
    int messages_sent = 0;
    int chars_checked = 0;
    int settings_used = 0;

    function automatic void push_char(logic [b128_pkg::SYM_W-1:0] c);
        if (line_pos >= line_len) begin
            group_chars.push_back(b128_pkg::CH_LF);
            line_pos = '0;
        end
        group_chars.push_back(c);
        line_pos = line_pos + 1'b1;
    endfunction

    function automatic void push_symbol(logic [b128_pkg::SYM_W-1:0] s);
        logic [b128_pkg::SYM_W-1:0] code;
        logic                       esc;
        esc = 1'b1;
        case (s)
            7'h3A: code = b128_pkg::CH_COLON;
            7'h00: code = 7'h30;
            7'h02: code = 7'h32;
            7'h03: code = 7'h33;
            7'h04: code = 7'h34;
            7'h05: code = 7'h35;
            7'h0D: code = 7'h41;
            7'h0A: code = 7'h42;
            7'h08: code = 7'h43;
            7'h09: code = 7'h44;
            7'h5E: code = 7'h45;
            default: begin
                esc  = 1'b0;
                code = s;
            end
        endcase
        if (esc) begin
            push_char(b128_pkg::CH_COLON);
        end
        push_char(code);
    endfunction

    function automatic void encode_byte(logic [7:0] d, logic msg_end);
        logic [b128_pkg::GROUP_W-1:0] acc;
        enc_char_t                    e;
        if (pending_fill < b128_pkg::GROUP_BYTES) pending_bytes[pending_fill] = d;
        pending_fill = pending_fill + 1'b1;
        if (pending_fill < b128_pkg::GROUP_BYTES && !msg_end) return;
        acc = pending_bytes;
        group_chars.delete();
        for (int i = 0; i < b128_pkg::GROUP_SYMS; i++)
            push_symbol(acc[b128_pkg::GROUP_W-1-b128_pkg::SYM_W*i -: b128_pkg::SYM_W]);
        pending_bytes = '0;
        pending_fill  = '0;
        if (msg_end) line_pos = '0;
        foreach (group_chars[i]) begin
            e.ch          = group_chars[i];
            e.run_last    = (i == group_chars.size() - 1);
            e.stream_last = e.run_last && msg_end;
            expected_chars.push_back(e);
        end
    endfunction

    // receiver back-pressure
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    // result checker
    always @(posedge aclk) begin
        enc_char_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected beat: char %h last %b user %b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                e = expected_chars.pop_front();
                chars_checked++;
                if (m_tdata !== {1'b0, e.ch} || m_tuser !== e.run_last
                        || m_tlast !== e.stream_last) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: exp char %h user %b last %b, got %h %b %b",
                                 {1'b0, e.ch}, e.run_last, e.stream_last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    // watchdog on stalled handshakes; surplus output beats are no progress
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn || (s_tvalid && s_tready)
                || (m_tvalid && m_tready && expected_chars.size() != 0)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", quiet);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_beat(logic [7:0] d, logic msg_end);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= msg_end;
        do @(posedge aclk); while (!s_tready);
        encode_byte(d, msg_end);
        bytes_sent++;
        if (msg_end) messages_sent++;
    endtask

    task automatic send_group(sym_group_t sg, int nbytes, logic msg_end);
        byte_group_t bg;
        bg = sg;
        for (int i = 0; i < nbytes; i++) send_beat(bg[i], msg_end && (i == nbytes - 1));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_line_length(logic [b128_pkg::LINE_LEN_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        line_len = v;
        settings_used++;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [b128_pkg::SYM_W-1:0] pick_symbol();
        logic [b128_pkg::SYM_W-1:0] esc_syms[11] = '{7'h3A, 7'h00, 7'h02, 7'h03, 7'h04,
                                                      7'h05, 7'h0D, 7'h0A, 7'h08, 7'h09,
                                                      7'h5E};
        if ($urandom_range(99) < 40) return esc_syms[$urandom_range(10)];
        return b128_pkg::SYM_W'($urandom_range(127));
    endfunction

    task automatic send_random_message(int len);
        sym_group_t sg;
        int         rem;
        int         n;
        rem = len;
        while (rem > 0) begin
            foreach (sg[i]) sg[i] = pick_symbol();
            n = (rem > b128_pkg::GROUP_BYTES) ? b128_pkg::GROUP_BYTES : rem;
            send_group(sg, n, rem <= b128_pkg::GROUP_BYTES);
            rem -= n;
        end
    endtask

    task automatic test_escape_symbols();
        // reset line length, every escaped symbol, full group closing a message
        send_group({7'h3A, 7'h00, 7'h02, 7'h03, 7'h04, 7'h05, 7'h0D, 7'h0A}, 7, 1'b0);
        send_group({7'h08, 7'h09, 7'h5E, 7'h7F, 7'h01, 7'h06, 7'h40, 7'h3F}, 7, 1'b1);
    endtask

    task automatic test_partial_groups();
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b1);
    endtask

    task automatic test_short_lines();
        set_line_length('0);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b1);
        set_line_length(10'd1);
        send_beat(8'h3A, 1'b1);
    endtask

    task automatic test_random_phase(int ipct, int spct,
                                     logic [b128_pkg::LINE_LEN_W-1:0] ll,
                                     int n_items, bit hold_off);
        int start;
        int len;
        set_line_length(ll);
        idle_pct  = ipct;
        stall_pct = spct;
        start = bytes_sent;
        if (hold_off) begin
            // stop mid-group until the encoder has nothing left to deliver
            send_random_message(10);
            send_beat(8'hC3, 1'b0);
            send_beat(8'h3C, 1'b0);
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (expected_chars.size() != 0);
            send_random_message(9);
        end
        while (bytes_sent - start < n_items) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            send_random_message(len);
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_escape_symbols();
        test_partial_groups();
        test_short_lines();
        test_random_phase(0, 0, 10'd1023, 58, 1'b1);
        test_random_phase(85, 0, 10'd1, 58, 1'b0);
        test_random_phase(0, 85, b128_pkg::LINE_LEN_W'($urandom_range(2, 100)), 58, 1'b0);
        test_random_phase(7, 7, b128_pkg::LINE_LEN_W'($urandom_range(1023)), 58, 1'b0);

        wait_drained();
        if (expected_chars.size() != 0) begin
            errors += expected_chars.size();
            $display("%0d expected characters never arrived", expected_chars.size());
        end
        $display("covered %0d bytes in %0d messages over %0d line lengths,",
                 bytes_sent, messages_sent, settings_used);
        $display("%0d characters checked, %0d errors", chars_checked, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
